// File: hw/rtl/stma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stma_pkg: shared types and constants of the sparse triplet merge-add core
// Payload structs, controller/datapath command and status bundles, codes.
// ----------------------------------------------------------------------------
package stma_pkg;

    localparam int COORD_W = 10;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 7;
    localparam int DIM_W   = 11;
    localparam int CFG_IW  = 2;

    localparam logic [POS_W-1:0] POS_MAX = 7'd127;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_ROWS_FIRST  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_COLS_FIRST  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ROWS_SECOND = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_COLS_SECOND = 2'd3;

    typedef struct packed {
        logic                     mode;
        logic                     has_entry;
        logic [COORD_W-1:0]       row_index;
        logic [COORD_W-1:0]       col_index;
        logic signed [VAL_W-1:0]  entry_value;
        logic                     list_end;
    } t_item;

    typedef struct packed {
        logic [COORD_W-1:0]       out_row;
        logic [COORD_W-1:0]       out_col;
        logic signed [VAL_W-1:0]  out_value;
        logic [POS_W-1:0]         out_position;
        logic [1:0]               out_status;
        logic                     out_last;
    } t_result;

    // what the datapath places in the result register
    typedef enum logic [2:0] {
        EMIT_NONE     = 3'd0,
        EMIT_STORED   = 3'd1,
        EMIT_INPUT    = 3'd2,
        EMIT_SUM      = 3'd3,
        EMIT_EMPTY    = 3'd4,
        EMIT_MISMATCH = 3'd5
    } t_emit;

    typedef struct packed {
        logic  take;      // latch the accepted second-list beat
        logic  store_wr;  // append a first-list beat to the store
        t_emit emit;
        logic  adv;       // advance the store read pointer
        logic  last;      // mark the emitted result as final
        logic  clear;     // drop all merge state
    } t_cmd;

    typedef struct packed {
        logic mismatch;     // matrix dimensions differ
        logic avail;        // a stored entry remains at the read pointer
        logic lt;           // stored key below the held key
        logic eq;           // stored key equal to the held key
        logic last_stored;  // read pointer sits on the final stored entry
    } t_sts;

endpackage
`default_nettype wire

// File: hw/rtl/stma_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stma_ctrl: merge sequencer
// Decides per cycle whether to emit a stored entry, the held entry, a sum or a status-only result.
// ----------------------------------------------------------------------------
module stma_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire           i_mode,
    input  wire           i_has,
    input  wire           i_end,
    input  stma_pkg::t_sts i_sts,
    output stma_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import stma_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_CMP   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_has, r_end, r_placed;
    logic   n_has, n_end, n_placed;
    logic   pend, eq_hit, rem;
    t_cmd   cmd;

    assign pend   = r_has && !r_placed;
    assign eq_hit = i_sts.avail && i_sts.eq;
    assign rem    = eq_hit ? !i_sts.last_stored : i_sts.avail;

    always_comb begin
        n_state  = r_state;
        n_has    = r_has;
        n_end    = r_end;
        n_placed = r_placed;
        cmd      = '0;
        cmd.emit = EMIT_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (!i_mode) begin
                        cmd.store_wr = 1'b1;
                    end else if (i_sts.mismatch) begin
                        if (i_end) begin
                            cmd.emit  = EMIT_MISMATCH;
                            cmd.last  = 1'b1;
                            cmd.clear = 1'b1;
                        end
                    end else begin
                        cmd.take = 1'b1;
                        n_has    = i_has;
                        n_end    = i_end;
                        n_placed = 1'b0;
                        n_state  = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (pend && i_sts.avail && i_sts.lt) begin
                    cmd.emit = EMIT_STORED;
                    cmd.adv  = 1'b1;
                    n_state  = S_FETCH;
                end else if (pend) begin
                    cmd.emit = eq_hit ? EMIT_SUM : EMIT_INPUT;
                    cmd.adv  = eq_hit;
                    n_placed = 1'b1;
                    if (!r_end) begin
                        n_state = S_IDLE;
                    end else if (!rem) begin
                        cmd.last  = 1'b1;
                        cmd.clear = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = eq_hit ? S_FETCH : S_CMP;
                    end
                end else if (r_end) begin
                    if (i_sts.avail) begin
                        cmd.emit = EMIT_STORED;
                        cmd.adv  = 1'b1;
                        if (i_sts.last_stored) begin
                            cmd.last  = 1'b1;
                            cmd.clear = 1'b1;
                            n_state   = S_IDLE;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end else begin
                        cmd.emit  = EMIT_EMPTY;
                        cmd.last  = 1'b1;
                        cmd.clear = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_has    <= 1'b0;
            r_end    <= 1'b0;
            r_placed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_has    <= n_has;
            r_end    <= n_end;
            r_placed <= n_placed;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// File: hw/rtl/stma_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stma_dp: merge datapath
// Dimension registers, first-list store, key compare, adder, result register.
// ----------------------------------------------------------------------------
module stma_dp #(
    parameter int LIST_DEPTH = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [stma_pkg::CFG_IW-1:0]       i_cfg_index,
    input  wire [stma_pkg::DIM_W-1:0]        i_cfg_data,
    input  stma_pkg::t_item                  i_item,
    input  stma_pkg::t_cmd                   i_cmd,
    output stma_pkg::t_sts                   o_sts,
    output logic                             o_result_strobe,
    output stma_pkg::t_result                o_result
);
    import stma_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int KW = 2 * COORD_W;
    localparam int EW = KW + VALUE_BITS;

    function automatic logic signed [VAL_W-1:0] sext(input logic signed [VALUE_BITS-1:0] v);
        return VAL_W'(v);
    endfunction

    logic [DIM_W-1:0]            r_dim [4];
    logic [EW-1:0]               r_mem [LIST_DEPTH];
    logic [EW-1:0]               r_rd;
    logic [COORD_W-1:0]          r_in_row, r_in_col;
    logic signed [VALUE_BITS-1:0] r_in_val;
    logic [CW-1:0]               r_count, r_ptr;
    logic [POS_W-1:0]            r_merged, n_merged;
    logic                        r_ovf;
    logic                        r_out_vld;
    t_result                     r_out, n_out;

    logic                        full;
    logic [KW-1:0]               key_st, key_in;
    logic [COORD_W-1:0]          rd_row, rd_col;
    logic signed [VALUE_BITS-1:0] rd_val, sum_val;
    logic [1:0]                  ok_status;
    logic                        counted;

    assign full    = (r_count == CW'(LIST_DEPTH));
    assign rd_row  = r_rd[EW-1 -: COORD_W];
    assign rd_col  = r_rd[VALUE_BITS +: COORD_W];
    assign rd_val  = r_rd[VALUE_BITS-1:0];
    assign key_st  = r_rd[EW-1 -: KW];
    assign key_in  = {r_in_row, r_in_col};
    assign sum_val = rd_val + r_in_val;

    assign o_sts.mismatch    = (r_dim[CFG_ROWS_FIRST] != r_dim[CFG_ROWS_SECOND]) ||
                               (r_dim[CFG_COLS_FIRST] != r_dim[CFG_COLS_SECOND]);
    assign o_sts.avail       = (r_ptr < r_count);
    assign o_sts.lt          = (key_st < key_in);
    assign o_sts.eq          = (key_st == key_in);
    assign o_sts.last_stored = ((r_ptr + CW'(1)) == r_count);

    assign ok_status = r_ovf ? ST_OVERFLOW : ST_OK;
    assign n_merged  = (r_merged == POS_MAX) ? r_merged : r_merged + POS_W'(1);
    assign counted   = (i_cmd.emit == EMIT_STORED) || (i_cmd.emit == EMIT_INPUT) ||
                       (i_cmd.emit == EMIT_SUM);

    always_comb begin
        n_out          = '0;
        n_out.out_last = i_cmd.last;
        case (i_cmd.emit)
            EMIT_STORED: begin
                n_out.out_row      = rd_row;
                n_out.out_col      = rd_col;
                n_out.out_value    = sext(rd_val);
                n_out.out_position = n_merged;
                n_out.out_status   = ok_status;
            end
            EMIT_INPUT: begin
                n_out.out_row      = r_in_row;
                n_out.out_col      = r_in_col;
                n_out.out_value    = sext(r_in_val);
                n_out.out_position = n_merged;
                n_out.out_status   = ok_status;
            end
            EMIT_SUM: begin
                n_out.out_row      = r_in_row;
                n_out.out_col      = r_in_col;
                n_out.out_value    = sext(sum_val);
                n_out.out_position = n_merged;
                n_out.out_status   = ok_status;
            end
            EMIT_EMPTY: begin
                n_out.out_status = ok_status;
            end
            EMIT_MISMATCH: begin
                n_out.out_status = ST_MISMATCH;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // store: one write port at the fill count, one registered read at the pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr && i_item.has_entry && !full) begin
            r_mem[r_count[AW-1:0]] <= {i_item.row_index, i_item.col_index,
                                       i_item.entry_value[VALUE_BITS-1:0]};
        end
        r_rd <= r_mem[r_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_in_row <= i_item.row_index;
            r_in_col <= i_item.col_index;
            r_in_val <= i_item.entry_value[VALUE_BITS-1:0];
        end
        if (i_cmd.emit != EMIT_NONE) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_dim[i] <= '0;
            end
            r_count   <= '0;
            r_ptr     <= '0;
            r_merged  <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dim[i_cfg_index] <= i_cfg_data;
            end
            if (i_cmd.store_wr && i_item.has_entry) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.adv) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (counted) begin
                r_merged <= n_merged;
            end
            r_out_vld <= (i_cmd.emit != EMIT_NONE);
            if (i_cmd.clear) begin
                r_count  <= '0;
                r_ptr    <= '0;
                r_merged <= '0;
                r_ovf    <= 1'b0;
            end
        end
    end

    assign o_result_strobe = r_out_vld;
    assign o_result        = r_out;

endmodule
`default_nettype wire

// File: hw/rtl/sparse_triplet_merge_add_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_triplet_merge_add_core: sparse matrix addition by triplet merge
// Adds two row-major sorted (row, column, value) lists into one merged list.
// ----------------------------------------------------------------------------
// Usage: write the four dimension registers while the core is idle, then
// stream first-list beats (mode 0), each taken without leaving idle and
// appended to a LIST_DEPTH-entry store (excess beats are dropped and every
// later result but a mismatch one carries the overflow status). Then stream
// second-list beats (mode 1). Each one is accepted, then holds the core in a
// fetch state and a compare state, with busy high in those two. Every stored
// entry with a smaller key emitted ahead of it adds a fetch and a compare;
// an equal key is summed in the compare state. The final beat of the second
// list also flushes the store, a fetch and a compare per remaining stored
// entry, except the first, which needs only a compare when the held entry
// matched no stored key and no step of its own when the beat carries no
// entry, since it is already fetched. Steps pair a fetch with a compare as
// the store's read port is registered: the fetch reads the entry at the read
// pointer, the compare compares keys, adds and emits. Second-list beats under
// mismatched dimensions do not hold the core. Each result is qualified by
// o_result_strobe, high for exactly one cycle; the receiver cannot stall
// them, so it must take every strobed beat. The final result of a merge has
// out_last set and clears the store for the next pair of lists. With
// mismatched dimensions second-list beats yield nothing until the final one,
// which yields a single status-only result. The store needs no clearing pass.
// ----------------------------------------------------------------------------
module sparse_triplet_merge_add_core #(
    parameter int LIST_DEPTH = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [stma_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire [stma_pkg::DIM_W-1:0]   i_cfg_data,
    input  wire                         start,
    output logic                        busy,
    input  stma_pkg::t_item             i_item,
    output logic                        o_result_strobe,
    output stma_pkg::t_result           o_result
);
    import stma_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: accepts beats, walks the store, issues one emit per step
    stma_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_item.mode),
        .i_has   (i_item.has_entry),
        .i_end   (i_item.list_end),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // datapath: dimension check, store, compare, add, result register
    stma_dp #(
        .LIST_DEPTH (LIST_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_item          (i_item),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    // a stored entry is emitted only while one remains under the pointer
    a_stored_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit == EMIT_STORED) |-> w_sts.avail)
        else $error("stored entry emitted past fill count");

    // the final result leaves the core idle and ready for the next list
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.out_last) |-> !busy)
        else $error("core still busy after final result");

    // only the final result may carry position zero
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_result.out_position == '0)) |-> o_result.out_last)
        else $error("non-final result without a position");

    // the store is written only from idle
    a_store_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !w_cmd.store_wr)
        else $error("store written during a merge step");

endmodule
`default_nettype wire
